// ----- rtl/frl_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Fixed-window rate limiter package
// Shared widths, register indexes and item, token and control structs.
// ----------------------------------------------------------------------------
package frl_pkg;

  localparam int unsigned KEY_FIELD_W = 32;
  localparam int unsigned TIME_W      = 32;
  localparam int unsigned COUNT_W     = 16;
  localparam int unsigned CFG_IDX_W   = 1;
  localparam int unsigned CFG_DATA_W  = 32;

  localparam int unsigned DEF_TABLE_ENTRIES = 64;
  localparam int unsigned DEF_KEY_BITS      = 32;

  localparam logic [COUNT_W-1:0] RESET_REQUEST_LIMIT  = 16'd5;
  localparam logic [TIME_W-1:0]  RESET_WINDOW_SECONDS = 32'd60;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_REQUEST_LIMIT  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_SECONDS = 1'd1;

  typedef struct packed {
    logic [KEY_FIELD_W-1:0] flow_key;
    logic [TIME_W-1:0]      now_seconds;
  } in_t;

  typedef struct packed {
    logic               allowed;
    logic [COUNT_W-1:0] remaining;
    logic [TIME_W-1:0]  window_left;
    logic               table_full;
  } out_t;

  typedef struct packed {
    logic [COUNT_W-1:0] request_limit;
    logic [TIME_W-1:0]  window_seconds;
  } cfg_t;

  // Search token that walks down the chain of cells, one cell per cycle.
  typedef struct packed {
    logic                   active;
    logic                   done;
    logic                   free_found;
    logic [KEY_FIELD_W-1:0] key;
    logic [TIME_W-1:0]      now;
    logic                   allowed;
    logic [COUNT_W-1:0]     remaining;
    logic [TIME_W-1:0]      window_left;
  } tok_t;

  // Broadcast write into the cell that claimed the first free entry.
  typedef struct packed {
    logic                   en;
    logic [KEY_FIELD_W-1:0] key;
    logic [TIME_W-1:0]      now;
    logic [COUNT_W-1:0]     count;
  } alloc_t;

endpackage : frl_pkg
`default_nettype wire

// ----- rtl/fixed_window_rate_limiter_top.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Fixed-window rate limiter
// Per-key request counting over fixed time windows in a chain of bucket cells.
// ----------------------------------------------------------------------------
// Usage: an input item (flow key, time in seconds) is taken when in_valid_i is
// high and in_stall_o is low. One result item (allowed, remaining quota,
// seconds until the window resets, table-full flag) comes out per input item
// on the out channel and is taken when out_valid_o is high and out_stall_i is
// low. The block handles one item at a time: a search token walks from the head
// register through the TABLE_ENTRIES bucket cells, one cell per cycle, and the
// result then passes through a pending register. A new key is written
// into the first free cell when the token leaves the chain. The result sits in
// an output register, so the next item is accepted while it waits; a stalled
// receiver holds the output stable and, once a second result is ready, holds
// the input side too. Reset empties the table and sets the limit to 5 requests
// and the window to 60 seconds. Configuration writes take effect at once; the
// user must make them while no item is in flight, which the block itself does
// not enforce.
// ----------------------------------------------------------------------------
module fixed_window_rate_limiter_top import frl_pkg::*; #(
  parameter int unsigned TABLE_ENTRIES = DEF_TABLE_ENTRIES,
  parameter int unsigned KEY_BITS      = DEF_KEY_BITS
) (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  wire                   cfg_we_i,
  input  wire [CFG_IDX_W-1:0]   cfg_idx_i,
  input  wire [CFG_DATA_W-1:0]  cfg_wdata_i,
  input  wire                   in_valid_i,
  output logic                  in_stall_o,
  input  in_t                   in_data_i,
  output logic                  out_valid_o,
  input  wire                   out_stall_i,
  output out_t                  out_data_o
);

  cfg_t   cfg_q;
  tok_t   head_q;
  tok_t   head_d;
  tok_t   chain [TABLE_ENTRIES+1];
  tok_t   last;
  alloc_t alloc;
  logic   busy_q;
  logic   pend_valid_q;
  out_t   pend_q;
  out_t   pend_d;
  logic   out_valid_q;
  out_t   out_q;
  logic   in_acc;
  logic   out_free;
  logic   new_allow;

  assign in_stall_o = busy_q;
  assign in_acc     = in_valid_i & ~busy_q;
  assign out_free   = ~out_valid_q | ~out_stall_i;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.request_limit  <= RESET_REQUEST_LIMIT;
      cfg_q.window_seconds <= RESET_WINDOW_SECONDS;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_REQUEST_LIMIT:  cfg_q.request_limit  <= cfg_wdata_i[COUNT_W-1:0];
        REG_WINDOW_SECONDS: cfg_q.window_seconds <= cfg_wdata_i[TIME_W-1:0];
        default: ;
      endcase
    end
  end

  // Token injection at the head of the chain.
  always_comb begin
    head_d        = '0;
    head_d.active = in_acc;
    head_d.key    = in_data_i.flow_key;
    head_d.now    = in_data_i.now_seconds;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q <= '0;
    end else begin
      head_q <= head_d;
    end
  end

  assign chain[0] = head_q;

  for (genvar i = 0; i < TABLE_ENTRIES; i++) begin : g_cell
    frl_cell #(
      .KEY_BITS (KEY_BITS)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .cfg_i   (cfg_q),
      .alloc_i (alloc),
      .tok_i   (chain[i]),
      .tok_o   (chain[i+1])
    );
  end

  assign last = chain[TABLE_ENTRIES];

  // Resolve the item at the end of the chain: a hit, a fresh bucket or a
  // full table. A fresh bucket starts its window now, so it has zero elapsed.
  assign new_allow = (cfg_q.request_limit != '0);

  always_comb begin
    alloc       = '0;
    alloc.key   = last.key;
    alloc.now   = last.now;
    alloc.count = new_allow ? COUNT_W'(1) : '0;
    pend_d      = '0;
    if (last.done) begin
      pend_d.allowed     = last.allowed;
      pend_d.remaining   = last.remaining;
      pend_d.window_left = last.window_left;
    end else if (last.free_found) begin
      alloc.en           = last.active;
      pend_d.allowed     = new_allow;
      pend_d.remaining   = new_allow ? cfg_q.request_limit - COUNT_W'(1) : '0;
      pend_d.window_left = cfg_q.window_seconds;
    end else begin
      pend_d.table_full  = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q       <= 1'b0;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      if (in_acc) begin
        busy_q <= 1'b1;
      end else if (pend_valid_q && out_free) begin
        busy_q <= 1'b0;
      end
      if (last.active) begin
        pend_valid_q <= 1'b1;
      end else if (out_free) begin
        pend_valid_q <= 1'b0;
      end
      if (out_free) begin
        out_valid_q <= pend_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (last.active) begin
      pend_q <= pend_d;
    end
    if (out_free && pend_valid_q) begin
      out_q <= pend_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule : fixed_window_rate_limiter_top
`default_nettype wire

// ----- rtl/frl_cell.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Fixed-window rate limiter cell
// Holds one bucket and updates it when the search token carries its key.
// ----------------------------------------------------------------------------
module frl_cell import frl_pkg::*; #(
  parameter int unsigned KEY_BITS = DEF_KEY_BITS
) (
  input  wire    clk_i,
  input  wire    rst_ni,
  input  cfg_t   cfg_i,
  input  alloc_t alloc_i,
  input  tok_t   tok_i,
  output tok_t   tok_o
);

  localparam int unsigned KEY_W = (KEY_BITS < KEY_FIELD_W) ? KEY_BITS : KEY_FIELD_W;

  logic               valid_q;
  logic               claim_q;
  logic [KEY_W-1:0]   key_q;
  logic [COUNT_W-1:0] count_q;
  logic [TIME_W-1:0]  start_q;
  tok_t               tok_q;
  tok_t               tok_d;

  logic               hit;
  logic               claim;
  logic               expired;
  logic               allow;
  logic               alloc_here;
  logic [TIME_W-1:0]  elapsed_old;
  logic [TIME_W-1:0]  elapsed;
  logic [COUNT_W-1:0] cnt_eff;
  logic [COUNT_W-1:0] count_d;

  assign hit = tok_i.active & ~tok_i.done & valid_q &
               (key_q == tok_i.key[KEY_W-1:0]);
  // Only the first invalid cell that a token passes claims the slot.
  assign claim      = tok_i.active & ~tok_i.free_found & ~valid_q;
  assign alloc_here = alloc_i.en & claim_q;

  // Difference wraps mod 2^32; a step back by d restarts if 2^32-d >= window.
  assign elapsed_old = tok_i.now - start_q;
  assign expired     = (elapsed_old >= cfg_i.window_seconds);
  assign cnt_eff     = expired ? '0 : count_q;
  assign elapsed     = expired ? '0 : elapsed_old;
  assign allow       = (cnt_eff < cfg_i.request_limit);
  assign count_d     = allow ? cnt_eff + COUNT_W'(1) : cnt_eff;

  always_comb begin
    tok_d = tok_i;
    if (hit) begin
      tok_d.done        = 1'b1;
      tok_d.allowed     = allow;
      tok_d.remaining   = allow ? cfg_i.request_limit - count_d : '0;
      tok_d.window_left = (cfg_i.window_seconds > elapsed) ?
                          cfg_i.window_seconds - elapsed : '0;
    end
    if (claim) begin
      tok_d.free_found = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      claim_q <= 1'b0;
      tok_q   <= '0;
    end else begin
      tok_q <= tok_d;
      if (tok_i.active) begin
        claim_q <= claim;
      end
      if (alloc_here) begin
        valid_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (alloc_here) begin
      key_q   <= alloc_i.key[KEY_W-1:0];
      count_q <= alloc_i.count;
      start_q <= alloc_i.now;
    end else if (hit) begin
      count_q <= count_d;
      if (expired) begin
        start_q <= tok_i.now;
      end
    end
  end

  assign tok_o = tok_q;

endmodule : frl_cell
`default_nettype wire

// ----- tb/tb_top.sv -----
// ----------------------------------------------------------------------------
// Fixed-window rate limiter testbench
// Sends flow requests over the input channel and checks each verdict against a
// bucket-table predictor kept in the bench. Directed cases come first: window
// expiry, clock wrap, a clock that steps back, zero limit, zero window, a
// lowered limit and the widest settings. Random bursts per flow run under
// several register settings, and the table is then filled until new keys are
// refused.
// ----------------------------------------------------------------------------
module tb_top;
  import frl_pkg::*;

  localparam int unsigned BUCKETS        = DEF_TABLE_ENTRIES;
  localparam int unsigned HOT_FLOWS      = 24;
  localparam int unsigned PHASES         = 8;
  localparam int unsigned PHASE_ITEMS    = 160;
  localparam int unsigned HOLD_CYCLES    = 400;
  localparam int unsigned WATCHDOG_LIMIT = 4000;
  localparam int unsigned TAIL_CYCLES    = DEF_TABLE_ENTRIES + 16;
  localparam int unsigned MAX_REPORTS    = 100;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx = REG_REQUEST_LIMIT;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  logic                  in_valid = 1'b0;
  in_t                   in_data = '0;
  logic                  in_stall;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  out_t                  out_data;

  // Bench copy of the registers and of the bucket table.
  logic [COUNT_W-1:0] limit_cfg = RESET_REQUEST_LIMIT;
  logic [TIME_W-1:0]  window_cfg = RESET_WINDOW_SECONDS;
  logic               bkt_valid [BUCKETS];
  logic [31:0]        bkt_key [BUCKETS];
  logic [COUNT_W-1:0] bkt_count [BUCKETS];
  logic [TIME_W-1:0]  bkt_start [BUCKETS];

  out_t        pending_verdicts [$];
  logic [31:0] hot_keys [HOT_FLOWS];
  logic [31:0] clock_now = '0;
  int          fail_count = 0;
  int          quiet_cycles = 0;
  logic        sender_quiet = 1'b0;
  logic        receiver_quiet = 1'b0;
  logic        hold_out_req = 1'b0;

  fixed_window_rate_limiter_top uut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data)
  );

  always #6 clk = ~clk;

  initial begin
    for (int i = 0; i < BUCKETS; i++) begin
      bkt_valid[i] = 1'b0;
      bkt_key[i]   = '0;
      bkt_count[i] = '0;
      bkt_start[i] = '0;
    end
  end

  // Looks up or claims the bucket of one request and returns its verdict.
  function automatic out_t rate_decide(input in_t req);
    int          hit;
    int          free_slot;
    logic [31:0] elapsed;
    out_t        verdict;
    hit = -1;
    free_slot = -1;
    verdict = '0;
    for (int i = 0; i < BUCKETS; i++) begin
      if (bkt_valid[i]) begin
        if (hit < 0 && bkt_key[i] == req.flow_key) hit = i;
      end else if (free_slot < 0) begin
        free_slot = i;
      end
    end
    if (hit < 0) begin
      if (free_slot < 0) begin
        verdict.table_full = 1'b1;
        return verdict;
      end
      hit = free_slot;
      bkt_valid[hit] = 1'b1;
      bkt_key[hit]   = req.flow_key;
      bkt_count[hit] = '0;
      bkt_start[hit] = req.now_seconds;
    end else begin
      elapsed = req.now_seconds - bkt_start[hit];
      if (elapsed >= window_cfg) begin
        bkt_count[hit] = '0;
        bkt_start[hit] = req.now_seconds;
      end
    end
    if (bkt_count[hit] < limit_cfg) begin
      bkt_count[hit]    = bkt_count[hit] + COUNT_W'(1);
      verdict.allowed   = 1'b1;
      verdict.remaining = limit_cfg - bkt_count[hit];
    end
    elapsed = req.now_seconds - bkt_start[hit];
    verdict.window_left = (window_cfg > elapsed) ? window_cfg - elapsed : '0;
    return verdict;
  endfunction

  function automatic int free_buckets();
    int n;
    n = 0;
    for (int i = 0; i < BUCKETS; i++) if (!bkt_valid[i]) n++;
    return n;
  endfunction

  function automatic int pick_gap();
    int roll;
    if (sender_quiet) return 0;
    roll = $urandom_range(0, 19);
    if (roll < 10) return 0;
    if (roll < 16) return $urandom_range(1, 4);
    if (roll < 19) return $urandom_range(5, 70);
    return $urandom_range(71, 200);
  endfunction

  task automatic send_item(input logic [31:0] key, input logic [31:0] now);
    in_t req;
    int  gap;
    req.flow_key    = key;
    req.now_seconds = now;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_verdicts.push_back(rate_decide(req));
  endtask

  // Stops offering items and waits until every verdict has come back.
  task automatic settle();
    in_valid <= 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_REQUEST_LIMIT) limit_cfg = data[COUNT_W-1:0];
    else window_cfg = data;
    @(posedge clk);
  endtask

  task automatic set_config(input logic [31:0] limit_word, input logic [31:0] window);
    settle();
    write_reg(REG_REQUEST_LIMIT, limit_word);
    write_reg(REG_WINDOW_SECONDS, window);
  endtask

  task automatic test_basic_window();
    for (int t = 100; t <= 105; t++) send_item(32'h0000_0000, t);
    // Exactly one window later the count starts over.
    send_item(32'h0000_0000, 32'd160);
  endtask

  task automatic test_time_wrap();
    send_item(32'hFFFF_FFFF, 32'hFFFF_FFF0);
    send_item(32'hFFFF_FFFF, 32'h0000_0010);
    // A clock that steps back looks like a very long gap.
    send_item(32'hA5A5_A5A5, 32'd1000);
    send_item(32'hA5A5_A5A5, 32'd999);
    send_item(32'h5A5A_5A5A, 32'hFFFF_FFFF);
  endtask

  task automatic test_zero_limit();
    // Only the low half of the write reaches the limit register.
    set_config(32'hABCD_0000, 32'd60);
    send_item(32'h1234_5678, 32'd170);
    send_item(32'h1234_5678, 32'd171);
    send_item(32'h0000_0000, 32'd172);
  endtask

  task automatic test_zero_window();
    set_config(32'd3, 32'd0);
    repeat (3) send_item(32'h0F0F_0F0F, 32'd500);
  endtask

  task automatic test_lowered_limit();
    set_config(32'd8, 32'd1000);
    repeat (4) send_item(32'hC3C3_C3C3, 32'd2000);
    set_config(32'd2, 32'd1000);
    send_item(32'hC3C3_C3C3, 32'd2001);
    send_item(32'hC3C3_C3C3, 32'd3000);
  endtask

  task automatic test_max_config();
    set_config(32'h0000_FFFF, 32'hFFFF_FFFF);
    send_item(32'h8000_0001, 32'd7);
    send_item(32'h8000_0001, 32'd7);
    send_item(32'h8000_0001, 32'd6);
  endtask

  task automatic test_random_traffic();
    logic [31:0] lim;
    logic [31:0] win;
    logic [31:0] key;
    int          step_max;
    int          sent;
    int          burst;
    foreach (hot_keys[i]) hot_keys[i] = $urandom;
    for (int phase = 0; phase < PHASES; phase++) begin
      case ($urandom_range(0, 7))
        0:       lim = 32'd0;
        1:       lim = 32'h0000_FFFF;
        default: lim = $urandom_range(1, 8);
      endcase
      lim[31:16] = 16'($urandom);
      case ($urandom_range(0, 7))
        0:       win = 32'd0;
        1:       win = 32'hFFFF_FFFF;
        2:       win = $urandom;
        default: win = $urandom_range(1, 40);
      endcase
      set_config(lim, win);
      step_max = (win != 0 && win <= 40) ? int'(win / 4) + 1 : 3;
      sender_quiet   = (phase == 5);
      receiver_quiet = (phase == 6);
      if (phase == 2) hold_out_req = 1'b1;
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        if ($urandom_range(0, 99) < 85) key = hot_keys[$urandom_range(0, HOT_FLOWS - 1)];
        else key = $urandom;
        burst = $urandom_range(1, 12);
        repeat (burst) begin
          case ($urandom_range(0, 19))
            0:       clock_now = $urandom;
            1:       clock_now = clock_now + win;
            default: clock_now = clock_now + $urandom_range(0, step_max);
          endcase
          send_item(key, clock_now);
          sent++;
        end
      end
    end
    sender_quiet   = 1'b0;
    receiver_quiet = 1'b0;
  endtask

  task automatic test_table_full();
    set_config(32'd2, 32'd30);
    while (free_buckets() > 0) begin
      clock_now = clock_now + $urandom_range(0, 3);
      send_item($urandom, clock_now);
    end
    repeat (3) send_item($urandom, $urandom);
    // Flows already in the table keep being served.
    send_item(32'h0000_0000, clock_now);
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_basic_window();
    test_time_wrap();
    test_zero_limit();
    test_zero_window();
    test_lowered_limit();
    test_max_config();
    test_random_traffic();
    test_table_full();
    settle();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("fixed_window_rate_limiter_top test passed");
    end else begin
      $display("fixed_window_rate_limiter_top test failed");
    end
    $finish;
  end

  // Receiver: random stalls, quiet stretches and one long hold-off on request.
  initial begin : receiver
    int held;
    @(posedge clk);
    forever begin
      if (hold_out_req) begin
        out_stall <= 1'b1;
        for (held = 0; held < HOLD_CYCLES; held++) @(posedge clk);
        hold_out_req = 1'b0;
      end else if (receiver_quiet) begin
        out_stall <= 1'b0;
        @(posedge clk);
      end else begin
        case ($urandom_range(0, 9))
          0, 1, 2, 3: begin
            out_stall <= 1'b0;
            repeat ($urandom_range(1, 40)) @(posedge clk);
          end
          4, 5, 6: begin
            out_stall <= 1'b1;
            repeat ($urandom_range(1, 3)) @(posedge clk);
          end
          7, 8: begin
            out_stall <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
          end
          default: begin
            out_stall <= 1'b1;
            repeat ($urandom_range(20, 150)) @(posedge clk);
          end
        endcase
      end
    end
  end

  task automatic check_field(input string what, input logic [31:0] want, input logic [31:0] got);
    if (want !== got) begin
      fail_count++;
      if (fail_count <= MAX_REPORTS)
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
    end
  endtask

  always @(posedge clk) begin : verdict_check
    out_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_verdicts.size() == 0) begin
        fail_count++;
        if (fail_count <= MAX_REPORTS)
          $display("%0t: result with no item pending, expected none, actual %h", $time, out_data);
      end else begin
        want = pending_verdicts.pop_front();
        check_field("allowed", 32'(want.allowed), 32'(out_data.allowed));
        check_field("remaining", 32'(want.remaining), 32'(out_data.remaining));
        check_field("window_left", want.window_left, out_data.window_left);
        check_field("table_full", 32'(want.table_full), 32'(out_data.table_full));
      end
    end
  end

  // Ends the run when neither channel has moved an item for too long.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("fixed_window_rate_limiter_top test failed");
      $finish;
    end
  end

endmodule

// ----- filelist.f -----
rtl/frl_pkg.sv
rtl/frl_cell.sv
rtl/fixed_window_rate_limiter_top.sv
tb/tb_top.sv
